// ===== hw/rtl/lsf_pkg.sv =====
// Shared types and codes for the least-squares line fit block.
// No dependencies; imported by lsf_accum, lsf_solve and the top level.
package lsf_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int COUNT_OUT_W = 13;
  localparam int RESULT_W    = 32;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;
  localparam logic [1:0] ST_DROP  = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] x_value;
    logic signed [SAMPLE_BITS-1:0] y_value;
    logic                          last_point;
  } lsf_in_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] slope;
    logic signed [RESULT_W-1:0] intercept;
    logic [COUNT_OUT_W-1:0]     point_count;
    logic [1:0]                 fit_status;
  } lsf_out_t;

endpackage

// ===== hw/rtl/lsf_accum.sv =====
// Front end: exact running sums, one point per cycle unless queue is full.
// Depends on lsf_pkg. Hands a finished set to the queue on the last point.
module lsf_accum
  import lsf_pkg::*;
#(
  parameter int MAX_POINTS = 4096,
  parameter int CNT_W      = 13,
  parameter int SX_W       = 25,
  parameter int SXX_W      = 37
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  lsf_in_t                 in_word,
  input  logic                    q_full,
  output logic                    snap_push,
  output logic [CNT_W-1:0]        snap_cnt,
  output logic signed [SX_W-1:0]  snap_sx,
  output logic signed [SX_W-1:0]  snap_sy,
  output logic signed [SXX_W-1:0] snap_sxx,
  output logic signed [SXX_W-1:0] snap_sxy,
  output logic                    snap_drop
);

  logic [CNT_W-1:0]        count_r;
  logic signed [SX_W-1:0]  sx_r, sy_r;
  logic signed [SXX_W-1:0] sxx_r, sxy_r;
  logic                    drop_r;

  logic                               accept, room;
  logic signed [2*SAMPLE_BITS-1:0]    xx, xy;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign room     = count_r < CNT_W'(MAX_POINTS);
  assign xx       = in_word.x_value * in_word.x_value;
  assign xy       = in_word.x_value * in_word.y_value;

  always_comb begin
    snap_cnt  = count_r;
    snap_sx   = sx_r;
    snap_sy   = sy_r;
    snap_sxx  = sxx_r;
    snap_sxy  = sxy_r;
    snap_drop = drop_r;
    if (room) begin
      snap_cnt = count_r + CNT_W'(1);
      snap_sx  = sx_r + SX_W'(in_word.x_value);
      snap_sy  = sy_r + SX_W'(in_word.y_value);
      snap_sxx = sxx_r + SXX_W'(xx);
      snap_sxy = sxy_r + SXX_W'(xy);
    end else begin
      snap_drop = 1'b1;
    end
  end

  assign snap_push = accept && in_word.last_point;

  always_ff @(posedge clk) begin
    if (!rst_n || snap_push) begin
      count_r <= '0;
      sx_r    <= '0;
      sy_r    <= '0;
      sxx_r   <= '0;
      sxy_r   <= '0;
      drop_r  <= 1'b0;
    end else if (accept) begin
      count_r <= snap_cnt;
      sx_r    <= snap_sx;
      sy_r    <= snap_sy;
      sxx_r   <= snap_sxx;
      sxy_r   <= snap_sxy;
      drop_r  <= snap_drop;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POINTS)) else $error("point count above capacity");

endmodule

// ===== hw/rtl/lsf_fifo.sv =====
// Small register queue that carries finished sets from front to back end.
// No dependencies beyond lsf_pkg conventions.
module lsf_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full  = cnt_r == CW'(DEPTH);
  assign empty = cnt_r == '0;
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
      if (pop && !empty) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      end
      cnt_r <= cnt_r + CW'(push && !full) - CW'(pop && !empty);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("push into full queue");

endmodule

// ===== hw/rtl/lsf_solve.sv =====
// Back end: forms the fit determinants with a serial multiplier and
// divides with a restoring serial divider. Depends on lsf_pkg.
module lsf_solve
  import lsf_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int CNT_W     = 13,
  parameter int SX_W      = 25,
  parameter int SXX_W     = 37
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    job_valid,
  output logic                    job_pop,
  input  logic [CNT_W-1:0]        job_cnt,
  input  logic signed [SX_W-1:0]  job_sx,
  input  logic signed [SX_W-1:0]  job_sy,
  input  logic signed [SXX_W-1:0] job_sxx,
  input  logic signed [SXX_W-1:0] job_sxy,
  input  logic                    job_drop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output lsf_out_t                out_word
);

  localparam int OW  = SXX_W + 1;
  localparam int NW  = 2 * OW + 1;
  localparam int DV  = NW + FRAC_BITS;
  localparam int QW  = RESULT_W + 1;
  localparam int MCW = $clog2(OW + 1);
  localparam int DCW = $clog2(DV + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MLOAD = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DLOAD = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]              state_r;
  logic signed [OW-1:0]    n_r, sx_r, sy_r, sxx_r, sxy_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    drop_r, degen_r, sat_r, pneg_r, neg_r, ovf_r, j_r;
  logic [2:0]              k_r;
  logic [MCW-1:0]          mstep_r;
  logic [DCW-1:0]          dstep_r;
  logic [2*OW-1:0]         mcand_r, prod_r;
  logic [OW-1:0]           mplier_r;
  logic signed [NW-1:0]    t_r, d_r, na_r, nb_r;
  logic [DV-1:0]           dvd_r;
  logic [NW-1:0]           rem_r;
  logic [QW-1:0]           q_r;
  logic signed [RESULT_W-1:0] slope_r, icpt_r;
  logic                    out_valid_r;
  lsf_out_t                out_r;

  logic signed [OW-1:0]    op_a, op_b;
  logic [OW-1:0]           mag_a, mag_b;
  logic [2*OW-1:0]         prod_sum;
  logic [NW-1:0]           pz;
  logic signed [NW-1:0]    p_s, diff, num;
  logic [NW-1:0]           num_mag;
  logic [NW:0]             sh, dpos;
  logic                    ge, ovf_n, sat_i;
  logic [QW-1:0]           q_n, lim, v;
  logic [RESULT_W-1:0]     res;
  logic                    out_load;

  always_comb begin
    case (k_r)
      3'd0: begin op_a = n_r;   op_b = sxx_r; end
      3'd1: begin op_a = sx_r;  op_b = sx_r;  end
      3'd2: begin op_a = n_r;   op_b = sxy_r; end
      3'd3: begin op_a = sx_r;  op_b = sy_r;  end
      3'd4: begin op_a = sxx_r; op_b = sy_r;  end
      3'd5: begin op_a = sxy_r; op_b = sx_r;  end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign mag_a    = op_a[OW-1] ? OW'(-op_a) : OW'(op_a);
  assign mag_b    = op_b[OW-1] ? OW'(-op_b) : OW'(op_b);
  assign prod_sum = prod_r + (mplier_r[0] ? mcand_r : '0);
  assign pz       = NW'(prod_sum);
  assign p_s      = pneg_r ? $signed(NW'(-pz)) : $signed(pz);
  assign diff     = t_r - p_s;

  assign num      = j_r ? nb_r : na_r;
  assign num_mag  = num[NW-1] ? NW'(-num) : NW'(num);

  assign sh       = {rem_r, dvd_r[DV-1]};
  assign dpos     = {1'b0, d_r};
  assign ge       = sh >= dpos;
  assign q_n      = {q_r[QW-2:0], ge};
  assign ovf_n    = ovf_r | q_r[QW-1];
  assign lim      = neg_r ? (QW'(1) << (RESULT_W - 1)) : ((QW'(1) << (RESULT_W - 1)) - QW'(1));
  assign sat_i    = ovf_n || (q_n > lim);
  assign v        = sat_i ? lim : q_n;
  assign res      = neg_r ? RESULT_W'(-v[RESULT_W-1:0]) : v[RESULT_W-1:0];

  assign job_pop  = (state_r == S_IDLE) && job_valid;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            state_r <= S_MLOAD;
          end
        end
        S_MLOAD: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (mstep_r == MCW'(OW - 1)) begin
            if (k_r == 3'd1 && diff <= 0) begin
              state_r <= S_DONE;
            end else if (k_r == 3'd5) begin
              state_r <= S_DLOAD;
            end else begin
              state_r <= S_MLOAD;
            end
          end
        end
        S_DLOAD: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (dstep_r == DCW'(DV - 1)) begin
            state_r <= j_r ? S_DONE : S_DLOAD;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers; sequencing is owned by state_r above.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        n_r     <= OW'($signed({1'b0, job_cnt}));
        sx_r    <= OW'(job_sx);
        sy_r    <= OW'(job_sy);
        sxx_r   <= OW'(job_sxx);
        sxy_r   <= OW'(job_sxy);
        cnt_r   <= job_cnt;
        drop_r  <= job_drop;
        degen_r <= 1'b0;
        sat_r   <= 1'b0;
        slope_r <= '0;
        icpt_r  <= '0;
        k_r     <= '0;
        j_r     <= 1'b0;
      end
      S_MLOAD: begin
        mcand_r  <= (2*OW)'(mag_a);
        mplier_r <= mag_b;
        prod_r   <= '0;
        pneg_r   <= op_a[OW-1] ^ op_b[OW-1];
        mstep_r  <= '0;
      end
      S_MUL: begin
        prod_r   <= prod_sum;
        mcand_r  <= mcand_r << 1;
        mplier_r <= mplier_r >> 1;
        mstep_r  <= mstep_r + MCW'(1);
        if (mstep_r == MCW'(OW - 1)) begin
          k_r <= k_r + 3'd1;
          case (k_r)
            3'd0, 3'd2, 3'd4: t_r <= p_s;
            3'd1: begin
              d_r     <= diff;
              degen_r <= diff <= 0;
            end
            3'd3: na_r <= diff;
            3'd5: nb_r <= diff;
            default: t_r <= p_s;
          endcase
        end
      end
      S_DLOAD: begin
        neg_r   <= num[NW-1];
        dvd_r   <= DV'(num_mag) << FRAC_BITS;
        rem_r   <= '0;
        q_r     <= '0;
        ovf_r   <= 1'b0;
        dstep_r <= '0;
      end
      S_DIV: begin
        rem_r   <= ge ? NW'(sh - dpos) : NW'(sh);
        dvd_r   <= dvd_r << 1;
        q_r     <= q_n;
        ovf_r   <= ovf_n;
        dstep_r <= dstep_r + DCW'(1);
        if (dstep_r == DCW'(DV - 1)) begin
          sat_r <= sat_r | sat_i;
          j_r   <= 1'b1;
          if (j_r) begin
            icpt_r <= res;
          end else begin
            slope_r <= res;
          end
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_r.slope       <= slope_r;
      out_r.intercept   <= icpt_r;
      out_r.point_count <= COUNT_OUT_W'(cnt_r);
      out_r.fit_status  <= degen_r ? ST_DEGEN : sat_r ? ST_SAT : drop_r ? ST_DROP : ST_OK;
    end
  end

  a_div_positive: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> d_r > 0) else $error("division by non-positive determinant");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.fit_status == ST_DEGEN |-> out_r.slope == 0 && out_r.intercept == 0)
    else $error("degenerate fit with nonzero result");

endmodule

// ===== hw/rtl/least_squares_line_fit.sv =====
// Top level of the least-squares line fit block.
// Depends on lsf_pkg, lsf_accum, lsf_fifo and lsf_solve.
//
// Usage: points arrive as words on the in_ channel (valid/ready). Every
// accepted point, up to MAX_POINTS per set, is added into exact sums of x,
// y, x*x, x*y and a count in the same cycle, so the front end takes one word
// per cycle while the queue is not full. A word with last_point set closes
// the set: its sums move into a two-entry queue and the accumulators restart
// at zero on the next word. The back end takes one set at a time from the
// queue. It forms six products with a serial shift-add multiplier (OW being
// the sum_xx width plus one, 38 by default) and then runs two restoring
// divisions of NW+FRAC_BITS bits each (NW = 2*OW+1). A determinant that is
// not positive skips the divisions after the second product.
// The result word waits in an output register; while it waits, the back end
// can finish the next set and the front end keeps accepting points until
// the queue is full, at which point in_ready drops.
// Reset (rst_n low, synchronous) empties the queue, clears all sums and
// drops any pending result.
module least_squares_line_fit
  import lsf_pkg::*;
#(
  parameter int MAX_POINTS = 4096,
  parameter int FRAC_BITS  = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  lsf_in_t  in_word,
  output logic     out_valid,
  input  logic     out_ready,
  output lsf_out_t out_word
);

  // Sum widths follow from the capacity so that no sum can wrap.
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SX_W  = SAMPLE_BITS + CNT_W;
  localparam int SXX_W = 2 * SAMPLE_BITS + CNT_W;
  localparam int SW    = CNT_W + 2 * SX_W + 2 * SXX_W + 1;

  logic                    q_full, q_empty, snap_push, job_pop;
  logic [CNT_W-1:0]        snap_cnt, job_cnt;
  logic signed [SX_W-1:0]  snap_sx, snap_sy, job_sx, job_sy;
  logic signed [SXX_W-1:0] snap_sxx, snap_sxy, job_sxx, job_sxy;
  logic                    snap_drop, job_drop;
  logic [SW-1:0]           q_din, q_dout;

  lsf_accum #(
    .MAX_POINTS(MAX_POINTS),
    .CNT_W     (CNT_W),
    .SX_W      (SX_W),
    .SXX_W     (SXX_W)
  ) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .q_full   (q_full),
    .snap_push(snap_push),
    .snap_cnt (snap_cnt),
    .snap_sx  (snap_sx),
    .snap_sy  (snap_sy),
    .snap_sxx (snap_sxx),
    .snap_sxy (snap_sxy),
    .snap_drop(snap_drop)
  );

  assign q_din = {snap_cnt, snap_sx, snap_sy, snap_sxx, snap_sxy, snap_drop};

  lsf_fifo #(
    .W    (SW),
    .DEPTH(2)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (snap_push),
    .din  (q_din),
    .full (q_full),
    .pop  (job_pop),
    .dout (q_dout),
    .empty(q_empty)
  );

  assign {job_cnt, job_sx, job_sy, job_sxx, job_sxy, job_drop} = q_dout;

  lsf_solve #(
    .FRAC_BITS(FRAC_BITS),
    .CNT_W    (CNT_W),
    .SX_W     (SX_W),
    .SXX_W    (SXX_W)
  ) u_solve (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_valid(!q_empty),
    .job_pop  (job_pop),
    .job_cnt  (job_cnt),
    .job_sx   (job_sx),
    .job_sy   (job_sy),
    .job_sxx  (job_sxx),
    .job_sxy  (job_sxy),
    .job_drop (job_drop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

endmodule
